@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the RTL files of this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define RRVM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition seen at one edge is followed by a property at the next edge.
`define RRVM_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/core/rrvm_pkg.sv @@
`default_nettype none

package rrvm_pkg;

    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned PAGES_W = 52;
    localparam int unsigned COUNT_W = 16;

    localparam logic [ADDR_W-1:0] SZ_64K       = 64'h0000_0000_0001_0000;
    localparam logic [ADDR_W-1:0] SZ_2M        = 64'h0000_0000_0020_0000;
    localparam logic [ADDR_W-1:0] PAGE_BYTES   = 64'h0000_0000_0000_1000;
    localparam logic [ADDR_W-1:0] SZ_512M      = 64'h0000_0000_2000_0000;
    localparam logic              RUNTIME_ATTR = 1'b1;

    localparam int unsigned LOW_W     = 16;   // log2 of SZ_64K
    localparam int unsigned ALIGN2M_W = 21;   // log2 of SZ_2M
    localparam int unsigned PAGE_SH   = 12;   // log2 of PAGE_BYTES

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        CFG_START_BASE = 2'd0,
        CFG_NO_REMAP   = 2'd1,
        CFG_FLAT       = 2'd2
    } t_cfg_idx;

    // Descriptor after the input register, with the state-free math done.
    typedef struct packed {
        logic              runtime;
        logic              last;
        logic [ADDR_W-1:0] phys;
        logic [LOW_W-1:0]  low;
        logic [ADDR_W-1:0] size;
        logic              align_2m;
    } t_desc;

    typedef struct packed {
        logic [ADDR_W-1:0]  virt;
        logic               keep;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/runtime_region_virtual_mapper.sv @@
`default_nettype none
// Runtime region virtual mapper. Each request on the slave stream is one memory-map
// descriptor (runtime flag on tuser, physical address and 4 KiB page count on tdata,
// end of map on tlast); each produces exactly one result on the master stream with the
// assigned virtual address, the keep flag and the running count of kept regions. A
// runtime region in normal mode is widened down to a 64 KiB boundary and placed at the
// running virtual base, aligned up to 2 MiB for large 2 MiB-aligned regions and to
// 64 KiB otherwise; the base then advances by the widened size. The block sustains one
// descriptor per clock while the result stream is not stalled. It has an input register,
// where the widened size and alignment class are formed, and a result register, written
// from the base update (an alignment increment followed by one 64-bit add). Configuration
// writes are taken in any cycle but must only be issued while the stream is idle; a new
// start base takes effect at the next end of map.

`include "assert_macros.svh"

module runtime_region_virtual_mapper
    import rrvm_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    // Configuration write channel.
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data,

    // Descriptor stream.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [119:0] s_axis_tdata,   // [63:0] physical address, [115:64] page count
    input  wire logic         s_axis_tuser,   // [0] is_runtime
    input  wire logic         s_axis_tlast,   // last_descriptor

    // Result stream.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [79:0]       m_axis_tdata,   // [63:0] virtual address, [79:64] kept_count
    output logic              m_axis_tuser    // [0] keep_region
);

    // Configuration registers.
    logic [ADDR_W-1:0] r_start_base;
    logic              r_no_remap;
    logic              r_flat;

    // Mapping state: running virtual base and count of kept regions.
    logic [ADDR_W-1:0]  r_base,  n_base;
    logic [COUNT_W-1:0] r_count, n_count;

    // Input register and result register.
    logic    r_s1_valid;
    t_desc   r_s1, n_s1;
    logic    r_out_valid;
    t_result r_out, n_out;

    logic s_fire;
    logic s1_fire;
    logic out_free;

    logic [ADDR_W-LOW_W-1:0]     base_up_64k;
    logic [ADDR_W-ALIGN2M_W-1:0] base_up_2m;
    logic [ADDR_W-1:0]           aligned_base;
    logic                        remap;

    // The config port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_base <= SZ_512M;
            r_no_remap   <= 1'b0;
            r_flat       <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_BASE: r_start_base <= i_cfg_data;
                CFG_NO_REMAP:   r_no_remap   <= i_cfg_data[0];
                CFG_FLAT:       r_flat       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake. The result register frees when empty or taken this cycle; the input
    // register frees when empty or when it moves into the result register.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_fire       = r_s1_valid && out_free;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Input stage: the widened size and the alignment class depend only on the
    // descriptor, so they are formed before the register. The page count shifted by
    // the page size fills exactly 64 bits; the sum wraps like the address arithmetic.
    always_comb begin
        n_s1.runtime  = s_axis_tuser;
        n_s1.last     = s_axis_tlast;
        n_s1.phys     = s_axis_tdata[ADDR_W-1:0];
        n_s1.low      = s_axis_tdata[LOW_W-1:0];
        n_s1.size     = {s_axis_tdata[ADDR_W+PAGES_W-1:ADDR_W], PAGE_SH'(0)}
                        + {{(ADDR_W-LOW_W){1'b0}}, s_axis_tdata[LOW_W-1:0]};
        n_s1.align_2m = (s_axis_tdata[ALIGN2M_W-1:0] == '0) && (|n_s1.size[ADDR_W-1:ALIGN2M_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_s1 <= n_s1;
        end
    end

    // Align-up of the running base is an increment of its upper bits whenever any bit
    // below the boundary is set; both candidates are formed and one is selected.
    assign base_up_64k = r_base[ADDR_W-1:LOW_W] + {{(ADDR_W-LOW_W-1){1'b0}}, |r_base[LOW_W-1:0]};
    assign base_up_2m  = r_base[ADDR_W-1:ALIGN2M_W]
                         + {{(ADDR_W-ALIGN2M_W-1){1'b0}}, |r_base[ALIGN2M_W-1:0]};
    assign aligned_base = r_s1.align_2m ? {base_up_2m, ALIGN2M_W'(0)} : {base_up_64k, LOW_W'(0)};

    // A runtime region is kept unless no-remap mode is on, which also wins over flat mode.
    assign remap = r_s1.runtime && !r_no_remap;

    always_comb begin
        n_base  = r_base;
        n_count = r_count;
        n_out.virt  = r_s1.phys;
        n_out.keep  = remap;
        if (remap) begin
            if (!r_flat) begin
                n_out.virt = aligned_base + {{(ADDR_W-LOW_W){1'b0}}, r_s1.low};
                n_base     = aligned_base + r_s1.size;
            end
            if (r_count != COUNT_MAX) begin
                n_count = r_count + COUNT_W'(1);
            end
        end
        // The result carries the count before the end-of-map clear.
        n_out.count = n_count;
        if (r_s1.last) begin
            n_base  = r_start_base;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= SZ_512M;
            r_count <= '0;
        end else if (s1_fire) begin
            r_base  <= n_base;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.count, r_out.virt};
    assign m_axis_tuser  = r_out.keep;

    // A descriptor held in the input register stays there while the output is blocked.
    `RRVM_ASSERT_NEXT(a_s1_holds, r_s1_valid && !out_free, r_s1_valid, "input stage item lost")
    // The end of the map always leaves the count cleared.
    `RRVM_ASSERT_NEXT(a_last_clears, s1_fire && r_s1.last, r_count == '0, "count not cleared")
    // A kept region has been counted.
    `RRVM_ASSERT(a_keep_counted, (r_out_valid && r_out.keep) |-> (r_out.count != '0),
                 "kept region without count")
    // The base only moves for a remapped region or at the end of the map.
    `RRVM_ASSERT_NEXT(a_base_stable, s1_fire && !r_s1.last && !(remap && !r_flat),
                      $stable(r_base), "base moved without a remapped region")

endmodule

`default_nettype wire

@@ bench/tb_runtime_region_virtual_mapper.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the runtime region virtual mapper.
module tb_runtime_region_virtual_mapper
    import rrvm_pkg::*;
();

    localparam int unsigned CLK_HALF     = 10;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned LONG_ITEMS   = 100;
    localparam int unsigned RAND_ITEMS   = 2000;
    localparam int unsigned NUM_PHASES   = 8;
    localparam int unsigned HOLD_CYCLES  = 400;

    // Tracks the mapper's running base and kept count and stores the mapping
    // that each accepted descriptor is expected to produce, oldest first.
    class mapping_scoreboard;
        logic [ADDR_W-1:0]  start_base;
        bit                 no_remap;
        bit                 flat;
        logic [ADDR_W-1:0]  next_base;
        logic [COUNT_W-1:0] kept;
        t_result            expected_maps[$];
        int unsigned        errors;

        function new();
            start_base = SZ_512M;
            no_remap   = 1'b0;
            flat       = 1'b0;
            next_base  = SZ_512M;
            kept       = '0;
            errors     = 0;
        endfunction

        // The start base only reaches the running base at the next end of map.
        function void apply_config(t_cfg_idx idx, logic [63:0] value);
            case (idx)
                CFG_START_BASE: start_base = value;
                CFG_NO_REMAP:   no_remap   = value[0];
                CFG_FLAT:       flat       = value[0];
                default: ;
            endcase
        endfunction

        function void note_descriptor(bit runtime, logic [ADDR_W-1:0] phys,
                                      logic [PAGES_W-1:0] pages, bit is_last);
            t_result           r;
            logic [ADDR_W-1:0] size;
            logic [ADDR_W-1:0] base;
            logic [ADDR_W-1:0] mask;
            logic [ADDR_W-1:0] low;
            r.virt = phys;
            r.keep = 1'b0;
            if (runtime && !no_remap) begin
                r.keep = 1'b1;
                if (!flat) begin
                    // Widen down to 64 KiB; the 2 MiB test looks at the wrapped size.
                    low  = {48'd0, phys[LOW_W-1:0]};
                    size = {pages, 12'h000} + low;
                    mask = ((phys[ALIGN2M_W-1:0] == '0) && (size >= SZ_2M)) ?
                           SZ_2M - 1 : SZ_64K - 1;
                    base = (next_base + mask) & ~mask;
                    r.virt    = base + low;
                    next_base = base + size;
                end
                if (kept != COUNT_MAX)
                    kept++;
            end
            r.count = kept;
            expected_maps.push_back(r);
            if (is_last) begin
                next_base = start_base;
                kept      = '0;
            end
        endfunction

        function void check_mapping(logic [ADDR_W-1:0] virt, bit keep,
                                    logic [COUNT_W-1:0] count);
            t_result e;
            if (expected_maps.size() == 0) begin
                $display("%0t: unexpected result virt=%h keep=%0d count=%0d",
                         $time, virt, keep, count);
                errors++;
                return;
            end
            e = expected_maps.pop_front();
            if (virt !== e.virt) begin
                $display("%0t: virtual address expected %h actual %h", $time, e.virt, virt);
                errors++;
            end
            if (keep !== e.keep) begin
                $display("%0t: keep_region expected %0d actual %0d", $time, e.keep, keep);
                errors++;
            end
            if (count !== e.count) begin
                $display("%0t: kept_count expected %0d actual %0d", $time, e.count, count);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index;
    logic [63:0]   i_cfg_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [119:0]  s_axis_tdata;
    logic          s_axis_tuser;
    logic          s_axis_tlast;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [79:0]   m_axis_tdata;
    logic          m_axis_tuser;

    mapping_scoreboard sb;

    // Idle rates in percent; the main sequence sets them per phase.
    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    // While set, the result side refuses every request so that the mapper backs up.
    logic        hold_rx;
    int unsigned cycle_count = 0;

    runtime_region_virtual_mapper u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side. Outputs are sampled at the edge, before the mapper's own
    // updates land, and tready is redrawn every cycle from the stall rate.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_mapping(m_axis_tdata[63:0], m_axis_tuser, m_axis_tdata[79:64]);
        if (hold_rx)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Writes all three registers back to back, keeping valid high across the
    // burst. Must only be called while no request is in flight.
    task automatic program_regs(logic [63:0] base, logic [63:0] no_remap_word,
                                logic [63:0] flat_word);
        t_cfg_idx    idxs[3];
        logic [63:0] vals[3];
        idxs = '{CFG_START_BASE, CFG_NO_REMAP, CFG_FLAT};
        vals = '{base, no_remap_word, flat_word};
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idxs[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.apply_config(idxs[i], vals[i]);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one descriptor after a random gap. tvalid stays high on return so
    // that back-to-back requests never lower and raise it in the same step.
    task automatic send_desc(bit runtime, logic [ADDR_W-1:0] phys,
                             logic [PAGES_W-1:0] pages, bit is_last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, pages, phys};
        s_axis_tuser  <= runtime;
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_descriptor(runtime, phys, pages, is_last);
    endtask

    // Mixes address and size classes so that both alignment paths, the
    // sub-64 KiB offset and the wrapping sizes all turn up often.
    task automatic send_random_desc(bit is_last);
        logic [ADDR_W-1:0]  phys;
        logic [PAGES_W-1:0] pages;
        logic [ADDR_W-1:0]  full;
        full = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2: phys = full;
            3, 4:    phys = full & ~(SZ_2M - 1);
            5, 6:    phys = full & ~(SZ_64K - 1);
            7:       phys = 64'($urandom_range(32'h000F_FFFF));
            8:       phys = '1;
            default: phys = '0;
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4: pages = PAGES_W'($urandom_range(64));
            5, 6:          pages = PAGES_W'(512 * $urandom_range(1, 8));
            7:             pages = PAGES_W'($urandom_range(4096));
            8:             pages = PAGES_W'({$urandom, $urandom});
            default:       pages = $urandom_range(1) ? '1 : '0;
        endcase
        send_desc($urandom_range(99) < 80, phys, pages, is_last);
    endtask

    // Idle point for register writes: every result is back, plus a margin
    // for the two-stage pipeline.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_maps.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] base;
        logic [63:0] nr_word;
        logic [63:0] flat_word;
        int unsigned map_left;

        sb            = new();
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_rx       <= 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_START_BASE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset configuration first: a non-runtime region with
        // every field at its top, a zero-length region, a 2 MiB class region,
        // an offset inside 64 KiB, an aligned but short region, a size that
        // wraps past 2^64, and an end of map.
        send_desc(1'b0, '1, '1, 1'b0);
        send_desc(1'b1, '0, '0, 1'b0);
        send_desc(1'b1, 64'h0000_0000_0020_0000, 52'd512, 1'b0);
        send_desc(1'b1, 64'h0000_0000_0001_2345, 52'd1, 1'b0);
        send_desc(1'b1, 64'h0000_0000_0060_0000, 52'h1FF, 1'b0);
        send_desc(1'b1, '1, '1, 1'b0);
        send_desc(1'b1, 64'h8000_0000_0000_0000, 52'h8_0000_0000_0000, 1'b0);
        send_desc(1'b0, '0, '0, 1'b1);

        // No-remap mode: runtime regions pass through and are not kept.
        wait_drained();
        program_regs(64'hFFFF_FFFF_FFFF_0000, 64'd1, 64'd0);
        send_desc(1'b1, 64'h0000_0000_0000_5000, 52'd3, 1'b0);
        send_desc(1'b1, '1, '1, 1'b1);

        // Both modes set: no-remap takes priority.
        wait_drained();
        program_regs(64'hFFFF_FFFF_FFFF_0000, 64'd1, 64'd1);
        send_desc(1'b1, 64'h0000_0000_0030_0000, 52'd1024, 1'b1);

        // Flat mode: one to one, but the region counts as kept.
        wait_drained();
        program_regs('1, 64'd0, 64'd1);
        send_desc(1'b1, 64'h0000_0000_ABCD_0000, 52'd16, 1'b0);
        send_desc(1'b0, 64'h0000_0000_0000_1000, 52'd2, 1'b1);

        // A start base near the top of the address space makes the aligned
        // base and the advanced base wrap.
        wait_drained();
        program_regs(64'hFFFF_FFFF_FFF0_0000, 64'd0, 64'd0);
        send_desc(1'b1, 64'h0000_0000_0020_0000, 52'd1024, 1'b0);
        send_desc(1'b1, 64'h0000_0001_0000_1234, 52'd5, 1'b0);
        send_desc(1'b1, 64'h0000_0000_0040_0000, 52'd600, 1'b1);

        // One longer map of runtime regions keeps the base advancing and the
        // kept count climbing before the end of map clears it.
        wait_drained();
        program_regs(SZ_512M, 64'd0, 64'd0);
        for (int unsigned n = 0; n < LONG_ITEMS; n++)
            send_desc(1'b1, {$urandom, $urandom}, PAGES_W'($urandom_range(40)), 1'b0);
        send_desc(1'b1, 64'h0000_0000_0001_0000, 52'd1, 1'b1);

        // Random part. Each phase picks an idling mix and a configuration;
        // the mode words carry random upper bits that the mapper must ignore.
        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            nr_word   = {$urandom, $urandom} & ~64'd1;
            flat_word = {$urandom, $urandom} & ~64'd1;
            case (p)
                0: base = SZ_512M;
                1: base = {$urandom, $urandom};
                2: base = 64'hFFFF_FFFF_FFF0_0000;
                3: begin
                    base      = '0;
                    flat_word = flat_word | 64'd1;
                end
                4: begin
                    base    = '1;
                    nr_word = nr_word | 64'd1;
                end
                5: begin
                    base      = {$urandom, $urandom};
                    nr_word   = nr_word | 64'd1;
                    flat_word = flat_word | 64'd1;
                end
                6: base = {$urandom, $urandom} & ~(SZ_64K - 1);
                default: begin
                    base      = {$urandom, $urandom};
                    nr_word   = nr_word | 64'($urandom_range(1));
                    flat_word = flat_word | 64'($urandom_range(1));
                end
            endcase
            program_regs(base, nr_word, flat_word);

            case (p % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 88;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 88;
                end
                default: begin
                    tx_idle_pct  = 25;
                    rx_stall_pct = 25;
                end
            endcase

            // In the first phase the result side holds off for a long stretch
            // while the sender keeps offering, so the input must stall.
            if (p == 0) begin
                fork
                    begin
                        hold_rx <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        hold_rx <= 1'b0;
                    end
                join_none
            end

            // Maps are mostly short; now and then a longer one. The last map
            // of a phase may be left open so that a start base written in
            // between only lands at the next end of map.
            map_left = 0;
            for (int unsigned n = 0; n < RAND_ITEMS / NUM_PHASES; n++) begin
                if (map_left == 0)
                    map_left = ($urandom_range(9) == 0) ? $urandom_range(20, 60) :
                                                          $urandom_range(1, 12);
                map_left--;
                send_random_desc(map_left == 0);
            end
        end

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.expected_maps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_maps.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
